/* rtl/skbs_pkg.sv */
// Shared constants, types and helpers for the sorted key binary search block.
package skbs_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 8192;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int PTR_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int SLOT_W  = 13;
    localparam int CP_W    = 21;
    localparam int WORD_W  = 32;
    localparam int CNT_W   = 14;
    localparam int ENTRY_W = CP_W + 2 * WORD_W;

    // Stream payload widths
    localparam int S_TDATA_W = ((SLOT_W + CP_W + 2 * WORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 2 * WORD_W;

    // s_tdata field positions
    localparam int SLOT_LSB = 0;
    localparam int CP_LSB   = SLOT_LSB + SLOT_W;
    localparam int OFF_LSB  = CP_LSB + CP_W;
    localparam int LEN_LSB  = OFF_LSB + WORD_W;

    // Request kinds carried on s_tuser
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1);

    // Controller to datapath commands
    typedef struct packed {
        logic load_we;    // write the accepted entry
        logic lookup;     // latch key, open the search range
        logic start;      // issue the first probe read
        logic probe;      // evaluate probe data, narrow the range
        logic take_hit;   // capture the probed entry as the result
        logic take_miss;  // capture an all-zero miss result
        logic push;       // move the captured result to the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic range_empty; // lo >= end before the first probe
        logic probe_hit;   // probed key equals search key
        logic probe_last;  // range empty after this probe
        logic out_free;    // output register can take a result
    } status_t;

    // Midpoint of the half-open range [lo, end), end > lo
    function automatic logic [ADDR_W-1:0] mid_of(input logic [PTR_W-1:0] lo,
                                                 input logic [PTR_W-1:0] hi_excl);
        logic [PTR_W:0] sum;
        sum = {1'b0, lo} + {1'b0, hi_excl} - (PTR_W+1)'(1);
        return ADDR_W'(sum >> 1);
    endfunction

endpackage

/* rtl/skbs_ram.sv */
// Generic simple dual-port RAM with registered read.
module skbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/skbs_ctrl.sv */
// Sequencing state machine for loads and binary search lookups.
module skbs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                req_kind,
    input  skbs_pkg::status_t   status,
    output skbs_pkg::cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_START  = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_PUSH   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (req_kind == skbs_pkg::CMD_LOOKUP) begin
                        cmd.lookup = 1'b1;
                        state_next = ST_START;
                    end else begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            ST_START: begin
                if (status.range_empty) begin
                    cmd.take_miss = 1'b1;
                    state_next    = ST_PUSH;
                end else begin
                    cmd.start  = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                cmd.probe = 1'b1;
                if (status.probe_hit) begin
                    cmd.take_hit = 1'b1;
                    state_next   = ST_PUSH;
                end else if (status.probe_last) begin
                    cmd.take_miss = 1'b1;
                    state_next    = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (status.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/skbs_dp.sv */
// Datapath: entry table, search range registers, compare and result registers.
module skbs_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [skbs_pkg::CNT_W-1:0]       cfg_wdata,
    input  logic [skbs_pkg::S_TDATA_W-1:0]   s_tdata,
    input  skbs_pkg::cmd_t                   cmd,
    output skbs_pkg::status_t                status,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [skbs_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [0:0]                       m_tuser
);

    localparam int ADDR_W = skbs_pkg::ADDR_W;
    localparam int PTR_W  = skbs_pkg::PTR_W;
    localparam int CP_W   = skbs_pkg::CP_W;
    localparam int WORD_W = skbs_pkg::WORD_W;

    logic [skbs_pkg::CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]             eff_count;
    logic [CP_W-1:0]              key_reg;
    logic [PTR_W-1:0]             lo_reg;
    logic [PTR_W-1:0]             end_reg;
    logic [ADDR_W-1:0]            mid_reg;
    logic [PTR_W-1:0]             lo_n;
    logic [PTR_W-1:0]             end_n;
    logic                         res_found_reg;
    logic [WORD_W-1:0]            res_off_reg;
    logic [WORD_W-1:0]            res_len_reg;
    logic                         m_tvalid_reg;
    logic                         m_found_reg;
    logic [WORD_W-1:0]            m_off_reg;
    logic [WORD_W-1:0]            m_len_reg;

    logic [skbs_pkg::SLOT_W-1:0]  in_slot;
    logic [CP_W-1:0]              in_key;
    logic                         slot_ok;
    logic                         ram_we;
    logic [skbs_pkg::ENTRY_W-1:0] ram_wdata;
    logic                         ram_re;
    logic [ADDR_W-1:0]            rd_addr;
    logic [skbs_pkg::ENTRY_W-1:0] rd_data;
    logic [CP_W-1:0]              rd_key;
    logic [WORD_W-1:0]            rd_off;
    logic [WORD_W-1:0]            rd_len;
    logic                         go_right;

    // Request field unpacking
    assign in_slot = s_tdata[skbs_pkg::SLOT_LSB +: skbs_pkg::SLOT_W];
    assign in_key  = s_tdata[skbs_pkg::CP_LSB +: CP_W];
    assign slot_ok = int'(in_slot) < skbs_pkg::TABLE_DEPTH;

    // Table write on a load request
    assign ram_we    = cmd.load_we && slot_ok;
    assign ram_wdata = {s_tdata[skbs_pkg::LEN_LSB +: WORD_W],
                        s_tdata[skbs_pkg::OFF_LSB +: WORD_W],
                        in_key};

    // Entry count register, clamped to the table depth
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= skbs_pkg::COUNT_RESET;
        end else if (cfg_we) begin
            count_reg <= cfg_wdata;
        end
    end

    assign eff_count = (int'(count_reg) > skbs_pkg::TABLE_DEPTH) ?
                       PTR_W'(skbs_pkg::TABLE_DEPTH) : PTR_W'(count_reg);

    // Probe evaluation against the entry read last cycle
    assign rd_key   = rd_data[CP_W-1:0];
    assign rd_off   = rd_data[CP_W +: WORD_W];
    assign rd_len   = rd_data[CP_W + WORD_W +: WORD_W];
    assign go_right = rd_key < key_reg;
    assign lo_n     = go_right ? (PTR_W'(mid_reg) + PTR_W'(1)) : lo_reg;
    assign end_n    = go_right ? end_reg : PTR_W'(mid_reg);

    // Next probe address: first midpoint at start, narrowed one after
    assign rd_addr = cmd.start ? skbs_pkg::mid_of(lo_reg, end_reg)
                               : skbs_pkg::mid_of(lo_n, end_n);
    assign ram_re  = cmd.start || cmd.probe;

    skbs_ram #(
        .WIDTH (skbs_pkg::ENTRY_W),
        .DEPTH (skbs_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ADDR_W'(in_slot)),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Search range [lo, end) and key
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg  <= '0;
            end_reg <= '0;
        end else if (cmd.lookup) begin
            lo_reg  <= '0;
            end_reg <= eff_count;
        end else if (cmd.probe) begin
            lo_reg  <= lo_n;
            end_reg <= end_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            key_reg <= in_key;
        end
        if (ram_re) begin
            mid_reg <= rd_addr;
        end
    end

    // Result capture
    always_ff @(posedge aclk) begin
        if (cmd.take_hit) begin
            res_found_reg <= 1'b1;
            res_off_reg   <= rd_off;
            res_len_reg   <= rd_len;
        end else if (cmd.take_miss) begin
            res_found_reg <= 1'b0;
            res_off_reg   <= '0;
            res_len_reg   <= '0;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_found_reg <= res_found_reg;
            m_off_reg   <= res_off_reg;
            m_len_reg   <= res_len_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {m_len_reg, m_off_reg};
    assign m_tuser[0] = m_found_reg;

    // Status to the controller
    assign status.range_empty = !(lo_reg < end_reg);
    assign status.probe_hit   = (rd_key == key_reg);
    assign status.probe_last  = !(lo_n < end_n);
    assign status.out_free    = !m_tvalid_reg || m_tready;

`ifndef SYNTHESIS
    a_range_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        lo_reg <= end_reg)
        else $error("search range inverted");

    a_range_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.probe && !status.probe_hit) |=>
            ((end_reg - lo_reg) < $past(end_reg - lo_reg)))
        else $error("search range did not shrink after a probe");

    a_first_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> (PTR_W'(rd_addr) < end_reg))
        else $error("first probe outside the search range");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (!m_tvalid_reg || m_tready))
        else $error("result pushed over a pending result");

    a_one_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.take_hit && cmd.take_miss))
        else $error("hit and miss captured together");
`endif

endmodule

/* rtl/sorted_key_binary_search.sv */
// Top level of the sorted key binary search block.
//
// Holds up to 8192 entries (code point, byte offset, byte length), sorted
// ascending by code point, in one table RAM.
// Input channel s_*: s_tuser carries the request kind. A load request writes
// the entry at its slot in the cycle it is accepted and gives no result.
// A lookup request runs a binary search over slots 0 .. entry_count-1.
// Result channel m_*: one result per lookup, found flag plus offset and
// length of the matching entry, or all zeros on a miss.
// cfg_we/cfg_wdata write entry_count (clamped to 8192). The user writes it
// only while idle; the block itself does not enforce this. Loads are taken
// one per cycle while no lookup is in progress. A lookup issues the first
// read, then evaluates one probe per table read (at most 14 for 8192
// entries), then pushes the result once the output register is free. The
// next probe address comes from comparing the key read from the table RAM.
// The next request is accepted in the cycle after the result is registered,
// even while that result still waits for m_tready. If the receiver stalls,
// a finished second lookup waits holding s_tready low.
// Reset (aresetn low, synchronous) clears the controller and output valid
// and sets entry_count to 1; table contents are undefined until loaded.
module sorted_key_binary_search (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration: entry_count
    input  logic                             cfg_we,
    input  logic [skbs_pkg::CNT_W-1:0]       cfg_wdata,
    // Request channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [12:0] slot, [33:13] code_point, [65:34] byte_offset,
    // [97:66] byte_length, [103:98] zero
    input  logic [skbs_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] cmd
    input  logic [0:0]                       s_tuser,
    // Result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] hit_offset, [63:32] hit_length
    output logic [skbs_pkg::M_TDATA_W-1:0]   m_tdata,
    // [0] found
    output logic [0:0]                       m_tuser
);

    skbs_pkg::cmd_t    cmd;
    skbs_pkg::status_t status;

    skbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_kind (s_tuser[0]),
        .status   (status),
        .cmd      (cmd)
    );

    skbs_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* dv/sorted_key_binary_search_test.sv */
// Self-checking stream testbench for the sorted key binary search block.
`timescale 1ns / 100ps

module sorted_key_binary_search_test;

    localparam int TABLE_DEPTH  = skbs_pkg::TABLE_DEPTH;
    localparam int SLOT_W       = skbs_pkg::SLOT_W;
    localparam int CP_W         = skbs_pkg::CP_W;
    localparam int WORD_W       = skbs_pkg::WORD_W;
    localparam int CNT_W        = skbs_pkg::CNT_W;
    localparam int S_TDATA_W    = skbs_pkg::S_TDATA_W;
    localparam int M_TDATA_W    = skbs_pkg::M_TDATA_W;

    localparam int CP_MAX       = (1 << CP_W) - 1;
    localparam int PAD_W        = S_TDATA_W - SLOT_W - CP_W - 2 * WORD_W;
    localparam int SETTLE       = 20;
    localparam int END_CYCLES   = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 3000;
    localparam int RANDOM_ITEMS = 1150;
    localparam int MAX_PRINTS   = 100;

    typedef struct packed {
        logic              found;
        logic [WORD_W-1:0] off;
        logic [WORD_W-1:0] len;
    } lookup_result_t;

    typedef enum logic [1:0] {ROW_LOAD, ROW_LOOKUP, ROW_COUNT} row_kind_t;

    // Count rows carry the new entry_count in off
    typedef struct {
        row_kind_t         kind;
        logic [SLOT_W-1:0] slot;
        logic [CP_W-1:0]   cp;
        logic [WORD_W-1:0] off;
        logic [WORD_W-1:0] len;
        bit                typed;
        lookup_result_t    want;
    } step_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CNT_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    // Shadow of the table and register
    logic [CP_W-1:0]      key_tbl [TABLE_DEPTH];
    logic [WORD_W-1:0]    off_tbl [TABLE_DEPTH];
    logic [WORD_W-1:0]    len_tbl [TABLE_DEPTH];
    bit                   written_slot [TABLE_DEPTH];
    logic [CNT_W-1:0]     count_reg = skbs_pkg::COUNT_RESET;

    lookup_result_t       pending_hits [$];
    step_row_t            opening_steps [$];
    int                   mismatches = 0;
    int                   items_sent = 0;
    int                   idle_cycles = 0;
    bit                   no_gaps = 1'b0;
    bit                   hold_outputs = 1'b0;

    sorted_key_binary_search dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int draw_gap();
        if (no_gaps || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    // Key given to a slot that a deep lookup reaches before it was loaded
    function automatic logic [CP_W-1:0] spread_key(input int slot);
        return CP_W'(slot * 256 + 128);
    endfunction

    // Binary search over the shadow table; stray flags a probe of an unwritten slot
    task automatic search_table(input logic [CP_W-1:0] key, output lookup_result_t r,
                                output bit stray);
        int n, lo, hi, mid;
        r = '0;
        stray = 1'b0;
        n = count_reg;
        if (n > TABLE_DEPTH)
            n = TABLE_DEPTH;
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
            mid = (lo + hi) >> 1;
            if (!written_slot[mid])
                stray = 1'b1;
            if (key_tbl[mid] == key) begin
                r.found = 1'b1;
                r.off   = off_tbl[mid];
                r.len   = len_tbl[mid];
                break;
            end
            if (key_tbl[mid] < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Offer one request, wait for it to be taken, then update the shadow
    task automatic send_request(input logic cmd, input logic [SLOT_W-1:0] slot,
                                input logic [CP_W-1:0] cp, input logic [WORD_W-1:0] off,
                                input logic [WORD_W-1:0] len, input bit typed,
                                input lookup_result_t want);
        int gap;
        lookup_result_t hit;
        bit stray;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{PAD_W{1'b0}}, len, off, cp, slot};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (cmd == skbs_pkg::CMD_LOAD) begin
            key_tbl[slot]      = cp;
            off_tbl[slot]      = off;
            len_tbl[slot]      = len;
            written_slot[slot] = 1'b1;
        end else begin
            search_table(cp, hit, stray);
            if (stray)
                report_mismatch("stimulus probes unwritten slot", WORD_W'(cp), '0);
            pending_hits.push_back(typed ? want : hit);
        end
    endtask

    task automatic issue_load(input logic [SLOT_W-1:0] slot, input logic [CP_W-1:0] cp);
        send_request(skbs_pkg::CMD_LOAD, slot, cp, $urandom(), $urandom(), 1'b0, '0);
    endtask

    task automatic issue_lookup(input logic [CP_W-1:0] cp);
        send_request(skbs_pkg::CMD_LOOKUP, '0, cp, $urandom(), $urandom(), 1'b0, '0);
    endtask

    // Register write once the block is drained
    task automatic write_count(input logic [CNT_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        count_reg = value;
        cfg_we <= 1'b0;
    endtask

    // Fill slots 0..n-1: style 0 ascending, 1 with duplicates, 2 unordered
    task automatic load_table(input int n, input int style);
        int cur, span;
        cur = $urandom_range(0, 64);
        for (int i = 0; i < n; i++) begin
            if (style == 2)
                issue_load(SLOT_W'(i), CP_W'($urandom_range(0, CP_MAX)));
            else
                issue_load(SLOT_W'(i), CP_W'(cur));
            span = (CP_MAX - cur) / (n - i);
            if (span < 1)
                span = 1;
            if (!(style == 1 && $urandom_range(0, 3) == 0))
                cur += $urandom_range(1, span);
            if (cur > CP_MAX)
                cur = CP_MAX;
        end
    endtask

    // Lookups: mostly stored keys, some neighbors and random keys, a few stray loads
    task automatic lookup_run(input int n, input int reqs);
        int r;
        logic [CP_W-1:0] k;
        for (int j = 0; j < reqs; j++) begin
            r = $urandom_range(0, 19);
            k = key_tbl[$urandom_range(0, n - 1)];
            if (r == 19)
                issue_load(SLOT_W'($urandom_range(0, TABLE_DEPTH - 1)),
                           CP_W'($urandom_range(0, CP_MAX)));
            else if (r < 12)
                issue_lookup(k);
            else if (r < 15)
                issue_lookup(r[0] ? k + 1'b1 : k - 1'b1);
            else
                issue_lookup(CP_W'($urandom_range(0, CP_MAX)));
        end
    endtask

    // Lookup in a large table: every slot on its search path is loaded first
    task automatic deep_lookup(input logic [CP_W-1:0] key);
        int n, lo, hi, mid;
        n = count_reg;
        if (n > TABLE_DEPTH)
            n = TABLE_DEPTH;
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
            mid = (lo + hi) >> 1;
            if (!written_slot[mid])
                issue_load(SLOT_W'(mid), spread_key(mid));
            if (key_tbl[mid] == key)
                break;
            if (key_tbl[mid] < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        issue_lookup(key);
    endtask

    // Deep lookups: spread keys, their neighbors and random keys
    task automatic deep_run(input int reqs);
        int r;
        logic [CP_W-1:0] k;
        for (int j = 0; j < reqs; j++) begin
            r = $urandom_range(0, 3);
            k = spread_key($urandom_range(0, TABLE_DEPTH - 1));
            if (r == 0)
                k = CP_W'($urandom_range(0, CP_MAX));
            else if (r == 1)
                k = k + 1'b1;
            deep_lookup(k);
        end
    endtask

    task automatic add_step(input row_kind_t kind, input logic [SLOT_W-1:0] slot,
                            input logic [CP_W-1:0] cp, input logic [WORD_W-1:0] off,
                            input logic [WORD_W-1:0] len, input bit typed,
                            input logic found, input logic [WORD_W-1:0] hoff,
                            input logic [WORD_W-1:0] hlen);
        step_row_t row;
        row.kind  = kind;
        row.slot  = slot;
        row.cp    = cp;
        row.off   = off;
        row.len   = len;
        row.typed = typed;
        row.want  = '{found: found, off: hoff, len: hlen};
        opening_steps.push_back(row);
    endtask

    // Result checker
    always @(posedge aclk) begin : result_check
        lookup_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_hits.size() == 0) begin
                report_mismatch("result with no lookup pending", m_tdata[31:0], '0);
            end else begin
                want = pending_hits.pop_front();
                if (m_tuser[0] !== want.found)
                    report_mismatch("found", WORD_W'(m_tuser[0]), WORD_W'(want.found));
                if (m_tdata[31:0] !== want.off)
                    report_mismatch("hit_offset", m_tdata[31:0], want.off);
                if (m_tdata[63:32] !== want.len)
                    report_mismatch("hit_length", m_tdata[63:32], want.len);
            end
        end
    end

    // Watchdog on cycles with no transfer at all
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result sink with random back-pressure and one long hold-off
    initial begin : result_sink
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = draw_gap();
            if (hold_outputs) begin
                gap = HOLD_CYCLES;
                hold_outputs = 1'b0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Request source
    initial begin : request_source
        int n, phase, style, r;
        for (int i = 0; i < TABLE_DEPTH; i++)
            written_slot[i] = 1'b0;

        // Opening table: extremes, empty table, duplicates, unordered keys
        add_step(ROW_LOAD,   0,    0,         32'hFFFFFFFF, 32'h0, 0, 0, 0, 0);
        add_step(ROW_LOOKUP, 0,    0,         0, 0, 1, 1, 32'hFFFFFFFF, 32'h0);
        add_step(ROW_LOOKUP, 0,    21'h1FFFFF, 0, 0, 1, 0, 0, 0);
        add_step(ROW_LOOKUP, 0,    1,         0, 0, 1, 0, 0, 0);
        add_step(ROW_LOAD,   8191, 21'h1FFFFF, 32'h0, 32'hFFFFFFFF, 0, 0, 0, 0);
        add_step(ROW_LOAD,   1,    21'h10FFFF, 32'h12345678, 32'hFFFFFFFF, 0, 0, 0, 0);
        add_step(ROW_LOAD,   2,    21'h1FFFFF, 32'hA5A5A5A5, 32'h5A5A5A5A, 0, 0, 0, 0);
        add_step(ROW_COUNT,  0,    0,         3, 0, 0, 0, 0, 0);
        add_step(ROW_LOOKUP, 0,    21'h10FFFF, 0, 0, 1, 1, 32'h12345678, 32'hFFFFFFFF);
        add_step(ROW_LOOKUP, 0,    21'h1FFFFF, 0, 0, 0, 0, 0, 0);
        add_step(ROW_LOOKUP, 0,    0,         0, 0, 0, 0, 0, 0);
        add_step(ROW_LOOKUP, 0,    5,         0, 0, 1, 0, 0, 0);
        add_step(ROW_COUNT,  0,    0,         0, 0, 0, 0, 0, 0);
        add_step(ROW_LOOKUP, 0,    0,         0, 0, 1, 0, 0, 0);
        add_step(ROW_LOOKUP, 0,    21'h1FFFFF, 0, 0, 1, 0, 0, 0);
        add_step(ROW_COUNT,  0,    0,         2, 0, 0, 0, 0, 0);
        add_step(ROW_LOAD,   1,    0,         1, 2, 0, 0, 0, 0);
        add_step(ROW_LOOKUP, 0,    0,         0, 0, 0, 0, 0, 0);
        add_step(ROW_LOAD,   0,    21'h100,   3, 4, 0, 0, 0, 0);
        add_step(ROW_LOOKUP, 0,    0,         0, 0, 0, 0, 0, 0);
        add_step(ROW_LOOKUP, 0,    21'h100,   0, 0, 0, 0, 0, 0);
        add_step(ROW_LOOKUP, 0,    21'h80000, 0, 0, 0, 0, 0, 0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (opening_steps[i]) begin
            case (opening_steps[i].kind)
                ROW_COUNT: begin
                    write_count(CNT_W'(opening_steps[i].off));
                end
                ROW_LOAD: begin
                    send_request(skbs_pkg::CMD_LOAD, opening_steps[i].slot,
                                 opening_steps[i].cp, opening_steps[i].off,
                                 opening_steps[i].len, 1'b0, '0);
                end
                default: begin
                    send_request(skbs_pkg::CMD_LOOKUP, '0, opening_steps[i].cp, $urandom(),
                                 $urandom(), opening_steps[i].typed, opening_steps[i].want);
                end
            endcase
        end

        // Random phases: small tables mostly, each drained before the count changes
        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r < 6)
                n = $urandom_range(1, 16);
            else if (r < 9)
                n = $urandom_range(17, 200);
            else
                n = $urandom_range(250, 300);
            r = $urandom_range(0, 9);
            style = (r < 7) ? 0 : (r < 9) ? 1 : 2;
            no_gaps = ($urandom_range(0, 4) == 0);
            write_count(CNT_W'(n));
            load_table(n, style);
            if (phase == 3)
                hold_outputs = 1'b1;
            lookup_run(n, $urandom_range(10, 40));
            phase++;
        end

        // Count at depth and above it, slots loaded along each search path
        no_gaps = 1'b0;
        write_count(CNT_W'(TABLE_DEPTH));
        deep_run(16);
        write_count('1);
        deep_run(8);
        write_count(CNT_W'(TABLE_DEPTH + 1));
        deep_run(8);

        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
